>>> hw/rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants
// Widths, ASCII codes, the double-dabble carrier type and the serialiser
// state encoding used across the decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int MAG_W           = 32;
  localparam int DIGITS          = 10;
  localparam int BCD_W           = 4 * DIGITS;
  localparam int STEPS_PER_STAGE = 8;
  localparam int DAB_STAGES      = MAG_W / STEPS_PER_STAGE;
  localparam int IDX_W           = $clog2(DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef logic [3:0] bcd_digit_t;

  // Carrier for the shift-and-add-3 conversion: decimal digits on the left,
  // binary bits still to be shifted in on the right.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] bin;
  } dab_t;

  typedef enum logic [1:0] {
    SER_IDLE,
    SER_SIGN,
    SER_DIGIT
  } ser_state_t;

endpackage

>>> hw/rtl/itoa_dabble_stage.sv
// ----------------------------------------------------------------------------
// itoa_dabble_stage: one registered slice of the binary to BCD conversion
// Performs a fixed number of shift-and-add-3 steps and registers the result
// with a valid bit; it advances whenever its register is empty or drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_dabble_stage
  import itoa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dab_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output dab_t out_data
);

  logic valid_r;
  dab_t data_r;
  dab_t data_nxt;

  always_comb begin
    dab_t w;
    w = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int k = 0; k < DIGITS; k++) begin
        if (w.bcd[k*4 +: 4] >= 4'd5) begin
          w.bcd[k*4 +: 4] = w.bcd[k*4 +: 4] + 4'd3;
        end
      end
      {w.bcd, w.bin} = {w.bcd[BCD_W-2:0], w.bin, 1'b0};
    end
    data_nxt = w;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hw/rtl/itoa_serializer.sv
// ----------------------------------------------------------------------------
// itoa_serializer: character emitter
// Takes a converted number, then sends through a registered output the sign of a
// negative number and the significant digits, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_serializer
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dab_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_text_char,
  output logic       out_is_last
);

  ser_state_t       state_r;
  ser_state_t       state_nxt;
  bcd_digit_t       digits_r [DIGITS];
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] top_idx;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic             slot_free;
  logic             load;
  logic             emit;
  logic             emit_digit;
  logic [7:0]       char_nxt;
  logic             last_nxt;
  ser_state_t       load_state;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == SER_IDLE) ||
                     ((state_r == SER_DIGIT) && (idx_r == '0) && slot_free);
  assign load      = in_valid && in_ready;
  assign load_state = in_data.neg ? SER_SIGN : SER_DIGIT;

  // Position of the most significant non-zero digit; zero keeps one digit.
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (in_data.bcd[k*4 +: 4] != 4'd0) begin
        top_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SER_IDLE: begin
        if (in_valid) state_nxt = load_state;
      end
      SER_SIGN: begin
        if (slot_free) state_nxt = SER_DIGIT;
      end
      SER_DIGIT: begin
        if (slot_free && (idx_r == '0)) state_nxt = in_valid ? load_state : SER_IDLE;
      end
      default: state_nxt = SER_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    emit_digit = 1'b0;
    char_nxt   = CHAR_ZERO;
    last_nxt   = 1'b0;
    case (state_r)
      SER_SIGN: begin
        emit     = slot_free;
        char_nxt = CHAR_MINUS;
      end
      SER_DIGIT: begin
        emit       = slot_free;
        emit_digit = slot_free;
        char_nxt   = CHAR_ZERO + {4'd0, digits_r[idx_r]};
        last_nxt   = (idx_r == '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SER_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < DIGITS; k++) begin
        digits_r[k] <= in_data.bcd[k*4 +: 4];
      end
      idx_r <= top_idx;
    end else if (emit_digit && (idx_r != '0)) begin
      idx_r <= idx_r - 1'b1;
    end
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_is_last   = out_last_r;

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal ASCII text
// Path: a request passes the front register, the dabble stages and the
// serialiser state before its first character is offered.
// Throughput: one character per cycle while the output is not stalled; a number
// of 1 to 11 characters (sign included) holds the emitter until its last is sent.
// Reset: synchronous, active low; it empties every pipeline stage and the
// output register, and no stored number survives it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Structure:
//   front stage   - takes the sign and forms the unsigned magnitude, so the
//                   most negative value becomes 2147483648 without overflow.
//   dabble stages - four registered slices of eight shift-and-add-3 steps
//                   each turn the 32-bit magnitude into ten BCD digits.
//   serialiser    - skips leading zeros, emits '-' for negative numbers and
//                   then the digits, most significant first, marking the final
//                   character with out_is_last.
// Every stage carries a valid bit and advances when its register is empty or
// its successor takes the contents, so a stall on the output holds the whole
// pipeline without losing or repeating a request.

module signed_int_to_decimal_ascii
  import itoa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_text_char,
  output logic              out_is_last
);

  logic                  front_valid_r;
  dab_t                  front_data_r;
  dab_t                  front_data_nxt;
  logic [MAG_W-1:0]      raw;

  dab_t                  dab_data  [DAB_STAGES+1];
  logic [DAB_STAGES:0]   dab_valid;
  logic [DAB_STAGES:0]   dab_ready;

  // Front stage: for a negative input the magnitude is the two's complement
  // negation taken as an unsigned quantity, which is exact for every 32-bit input.
  assign raw = in_value;

  always_comb begin
    front_data_nxt.neg = raw[MAG_W-1];
    front_data_nxt.bcd = '0;
    front_data_nxt.bin = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
  end

  assign in_ready = !front_valid_r || dab_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (in_ready) begin
      front_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      front_data_r <= front_data_nxt;
    end
  end

  assign dab_valid[0] = front_valid_r;
  assign dab_data[0]  = front_data_r;

  // Binary to BCD conversion, a fixed share of the shift steps per stage.
  for (genvar i = 0; i < DAB_STAGES; i++) begin : g_dabble
    itoa_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dab_valid[i]),
      .in_ready  (dab_ready[i]),
      .in_data   (dab_data[i]),
      .out_valid (dab_valid[i+1]),
      .out_ready (dab_ready[i+1]),
      .out_data  (dab_data[i+1])
    );
  end

  // Character emitter with its own registered output.
  itoa_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (dab_valid[DAB_STAGES]),
    .in_ready      (dab_ready[DAB_STAGES]),
    .in_data       (dab_data[DAB_STAGES]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_is_last   (out_is_last)
  );

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for signed_int_to_decimal_ascii
// Feeds signed 32-bit requests through the valid/ready input, predicts the
// decimal character stream of every accepted request, and compares each
// character and end marker leaving the block in order, under random idling
// on both sides, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_itoa_pkg;
  import itoa_pkg::*;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } text_char_t;

  class ascii_scoreboard;
    text_char_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Expands one accepted request into the characters it must produce.
    function void note_request(logic [31:0] value);
      logic [31:0] magnitude;
      logic [3:0]  digit [DIGITS];
      int          n;
      text_char_t  c;
      magnitude = value[31] ? (32'd0 - value) : value;
      n = 0;
      do begin
        digit[n]  = 4'(magnitude % 32'd10);
        magnitude = magnitude / 32'd10;
        n++;
      end while (magnitude != 32'd0);
      if (value[31]) begin
        c.text_char = CHAR_MINUS;
        c.is_last   = 1'b0;
        pending_chars.push_back(c);
      end
      for (int k = n - 1; k >= 0; k--) begin
        c.text_char = CHAR_ZERO + {4'd0, digit[k]};
        c.is_last   = (k == 0);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] text_char, logic is_last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: character 0x%02h (last %0b) arrived with none outstanding",
                 $time, text_char, is_last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (text_char !== want.text_char) begin
        $display("%0t: text_char expected 0x%02h, got 0x%02h",
                 $time, want.text_char, text_char);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: is_last expected %0b, got %0b", $time, want.is_last, is_last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

endpackage

module tb;
  import itoa_pkg::*;
  import tb_itoa_pkg::*;

  // Generous ceiling: roughly 250 requests of up to eleven characters, each
  // character with a random receiver idle, plus the long stall and the drains.
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 150;
  // The tail wait leaves room for any stray character after the last one.
  localparam int TAIL_CYCLES = 30;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic signed [31:0] in_value;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_text_char;
  logic              out_is_last;

  ascii_scoreboard   sb;
  int                cycle_count;
  // When set, neither side inserts idle cycles.
  bit                quiet;
  // A nonzero value asks the receiver to hold off; the receiver counts it out.
  int                stall_request;

  signed_int_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_is_last   (out_is_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one request. It is entered on a falling edge and returns on the
  // falling edge after acceptance with in_valid still high, so that a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic offer_request(input logic [31:0] value);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value <= value;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(value);
    @(negedge clk);
  endtask

  // Withdraws the input and waits until every predicted character has left.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic longint pow10(int k);
    longint p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Random requests spread over every digit count, the powers of ten and
  // their neighbours, the range limits, and raw 32-bit patterns.
  function automatic logic [31:0] draw_value();
    int          mode;
    int          len;
    longint      lo;
    longint      hi;
    longint      magnitude;
    logic [31:0] value;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      value = $urandom;
    end else if (mode < 8) begin
      len = $urandom_range(1, 10);
      lo  = (len == 1) ? 0 : pow10(len - 1);
      hi  = pow10(len) - 1;
      if (hi > 64'd2147483647) hi = 64'd2147483647;
      magnitude = lo + $urandom_range(0, 32'(hi - lo));
      value = magnitude[31:0];
      if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
    end else if (mode == 8) begin
      magnitude = pow10($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
      value = magnitude[31:0];
      if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
    end else begin
      case ($urandom_range(0, 3))
        0:       value = 32'h0000_0000;
        1:       value = 32'h8000_0000;
        2:       value = 32'h7FFF_FFFF;
        default: value = 32'hFFFF_FFFF;
      endcase
    end
    return value;
  endfunction

  // Receiver: random readiness per character, with an occasional long hold
  // that the stimulus asks for and this process counts out itself.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        gap = stall_request;
        stall_request = 0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_char(out_text_char, out_is_last);
    end
  end

  // Stimulus: directed corner values, a burst against a stalled output, a
  // stretch with no idling at all, then a long randomised run.
  initial begin
    logic [31:0] directed [$];
    sb            = new();
    quiet         = 1'b0;
    stall_request = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero, single digits, several digit-count boundaries, both range limits
    // (the most negative value must come out as eleven characters) and
    // alternating bit patterns.
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                 32'd99, 32'd100, 32'd999999999, 32'd1000000000,
                 32'hC465_3600, 32'd2147483647, 32'h8000_0000, 32'h8000_0001,
                 32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7};
    foreach (directed[i]) offer_request(directed[i]);

    // Hold the output off for a long stretch while requests keep coming, so
    // the pipeline fills and the input stalls.
    drain_outputs();
    stall_request = LONG_STALL;
    repeat (20) offer_request(draw_value());

    // Pause the input until everything has come out, then run flat out.
    drain_outputs();
    quiet = 1'b1;
    repeat (40) offer_request(draw_value());
    quiet = 1'b0;
    drain_outputs();

    repeat (160) offer_request(draw_value());
    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
